[rtl/core/ps2kd_pkg.sv]
`timescale 1ns / 1ps

package ps2kd_pkg;

	localparam logic [7:0] CODE_RELEASE = 8'hF0;
	localparam logic [7:0] CODE_LSHIFT  = 8'h12;
	localparam logic [7:0] CODE_LCTRL   = 8'h14;
	localparam logic [7:0] CODE_EOT_KEY = 8'h23;
	localparam logic [7:0] CHAR_EOT     = 8'h04;
	localparam int unsigned MAP_SIZE    = 112;

	typedef logic [7:0] char_t;

	localparam char_t LOWER_MAP [0:MAP_SIZE-1] = '{
		8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
		8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
		8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h71, 8'h31, 8'h00,
		8'h00, 8'h00, 8'h7A, 8'h73, 8'h61, 8'h77, 8'h32, 8'h00,
		8'h00, 8'h63, 8'h78, 8'h64, 8'h65, 8'h34, 8'h33, 8'h00,
		8'h00, 8'h20, 8'h76, 8'h66, 8'h74, 8'h72, 8'h35, 8'h00,
		8'h00, 8'h6E, 8'h62, 8'h68, 8'h67, 8'h79, 8'h36, 8'h00,
		8'h00, 8'h00, 8'h6D, 8'h6A, 8'h75, 8'h37, 8'h38, 8'h00,
		8'h00, 8'h2C, 8'h6B, 8'h69, 8'h6F, 8'h30, 8'h39, 8'h00,
		8'h00, 8'h2E, 8'h2F, 8'h6C, 8'h3B, 8'h70, 8'h2D, 8'h00,
		8'h00, 8'h00, 8'h27, 8'h00, 8'h5B, 8'h3D, 8'h00, 8'h00,
		8'h00, 8'h00, 8'h0D, 8'h5D, 8'h00, 8'h5C, 8'h00, 8'h00,
		8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h08, 8'h00,
		8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
	};

	localparam char_t UPPER_MAP [0:MAP_SIZE-1] = '{
		8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
		8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
		8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h51, 8'h21, 8'h00,
		8'h00, 8'h00, 8'h5A, 8'h53, 8'h41, 8'h57, 8'h40, 8'h00,
		8'h00, 8'h43, 8'h58, 8'h44, 8'h45, 8'h24, 8'h23, 8'h00,
		8'h00, 8'h20, 8'h56, 8'h46, 8'h54, 8'h52, 8'h25, 8'h00,
		8'h00, 8'h4E, 8'h42, 8'h48, 8'h47, 8'h59, 8'h5E, 8'h00,
		8'h00, 8'h00, 8'h4D, 8'h4A, 8'h55, 8'h26, 8'h2A, 8'h00,
		8'h00, 8'h3C, 8'h4B, 8'h49, 8'h4F, 8'h29, 8'h28, 8'h00,
		8'h00, 8'h3E, 8'h3F, 8'h4C, 8'h3A, 8'h50, 8'h5F, 8'h00,
		8'h00, 8'h00, 8'h22, 8'h00, 8'h7B, 8'h2B, 8'h00, 8'h00,
		8'h00, 8'h00, 8'h0D, 8'h7D, 8'h00, 8'h7C, 8'h00, 8'h00,
		8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h08, 8'h00,
		8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
	};

	function automatic char_t map_code(input logic [7:0] code, input logic shift,
			input logic ctrl);
		char_t c;
		c = 8'h00;
		if (code < 8'(MAP_SIZE)) begin
			c = shift ? UPPER_MAP[code[6:0]] : LOWER_MAP[code[6:0]];
		end
		if (ctrl && code == CODE_EOT_KEY) begin
			c = CHAR_EOT;
		end
		return c;
	endfunction

endpackage

[rtl/core/ps2kd_ram.sv]
`timescale 1ns / 1ps

module ps2kd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [0:DEPTH-1];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

[rtl/core/ps2_set2_keyboard_decoder_fifo_top.sv]
`timescale 1ns / 1ps

// PS/2 set 2 scan code decoder with a character FIFO. Each input beat is either a scan
// byte (action 0) or a read request (action 1) and returns exactly one result beat. A beat
// is accepted every cycle while the output side keeps up; its result passes through two
// registered stages, the first being the read port of the character RAM. Key flags,
// the ROM lookup and the FIFO pointers all settle in the cycle the beat is accepted, so
// back-to-back writes and reads of the same entry need no forwarding. A stalled output
// freezes the whole two-stage pipe. The FIFO holds BUFFER_DEPTH characters; when full a
// new character is dropped and flagged, and a read of an empty FIFO returns zero.
module ps2_set2_keyboard_decoder_fifo_top #(
	parameter int BUFFER_DEPTH = 128
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic       action,
	input  logic [7:0] scan_code,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] read_char,
	output logic       read_valid,
	output logic       char_stored,
	output logic       char_dropped,
	output logic [7:0] fill_count
);

	import ps2kd_pkg::*;

	localparam int AW = $clog2(BUFFER_DEPTH);
	localparam int CW = $clog2(BUFFER_DEPTH + 1);

	logic          advance;
	logic          accept;

	logic          rel_q, rel_d;
	logic          shift_q, shift_d;
	logic          ctrl_q, ctrl_d;
	logic [AW-1:0] wr_idx_q, wr_idx_d;
	logic [AW-1:0] rd_idx_q, rd_idx_d;
	logic [CW-1:0] count_q, count_d;

	logic          ram_we;
	logic          ram_re;
	char_t         wr_char;
	char_t         ram_rdata;

	logic          rvalid_c, stored_c, dropped_c;
	logic [CW+7:0] count_ext;

	logic          valid_s1;
	logic          rvalid_s1, stored_s1, dropped_s1;
	logic [7:0]    fill_s1;

	assign advance  = !out_valid || !out_stall;
	assign in_stall = !advance;
	assign accept   = in_valid && advance;

	always_comb begin
		rel_d     = rel_q;
		shift_d   = shift_q;
		ctrl_d    = ctrl_q;
		wr_idx_d  = wr_idx_q;
		rd_idx_d  = rd_idx_q;
		count_d   = count_q;
		ram_we    = 1'b0;
		ram_re    = 1'b0;
		rvalid_c  = 1'b0;
		stored_c  = 1'b0;
		dropped_c = 1'b0;
		wr_char   = map_code(scan_code, shift_d, ctrl_d);
		if (accept) begin
			if (action) begin
				if (count_q != '0) begin
					ram_re   = 1'b1;
					rvalid_c = 1'b1;
					rd_idx_d = (rd_idx_q == AW'(BUFFER_DEPTH - 1)) ? '0 : rd_idx_q + AW'(1);
					count_d  = count_q - CW'(1);
				end
			end else if (scan_code == CODE_RELEASE) begin
				rel_d = 1'b1;
			end else begin
				if (scan_code == CODE_LSHIFT) begin
					shift_d = !rel_q;
				end
				if (scan_code == CODE_LCTRL) begin
					ctrl_d = !rel_q;
				end
				wr_char = map_code(scan_code, shift_d, ctrl_d);
				if (rel_q && scan_code != 8'h00) begin
					rel_d = 1'b0;
				end else if (count_q == CW'(BUFFER_DEPTH)) begin
					dropped_c = 1'b1;
				end else begin
					ram_we   = 1'b1;
					stored_c = 1'b1;
					wr_idx_d = (wr_idx_q == AW'(BUFFER_DEPTH - 1)) ? '0 : wr_idx_q + AW'(1);
					count_d  = count_q + CW'(1);
				end
			end
		end
	end

	assign count_ext = {8'h00, count_d};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rel_q    <= 1'b0;
			shift_q  <= 1'b0;
			ctrl_q   <= 1'b0;
			wr_idx_q <= '0;
			rd_idx_q <= '0;
			count_q  <= '0;
		end else begin
			rel_q    <= rel_d;
			shift_q  <= shift_d;
			ctrl_q   <= ctrl_d;
			wr_idx_q <= wr_idx_d;
			rd_idx_q <= rd_idx_d;
			count_q  <= count_d;
		end
	end

	ps2kd_ram #(
		.WIDTH(8),
		.DEPTH(BUFFER_DEPTH)
	) u_ring (
		.clk  (clk),
		.we   (ram_we),
		.waddr(wr_idx_q),
		.wdata(wr_char),
		.re   (ram_re),
		.raddr(rd_idx_q),
		.rdata(ram_rdata)
	);

	// advance both stages together; a stalled output holds everything
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			out_valid <= 1'b0;
		end else if (advance) begin
			valid_s1  <= accept;
			out_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			rvalid_s1    <= rvalid_c;
			stored_s1    <= stored_c;
			dropped_s1   <= dropped_c;
			fill_s1      <= count_ext[7:0];
			read_char    <= rvalid_s1 ? ram_rdata : 8'h00;
			read_valid   <= rvalid_s1;
			char_stored  <= stored_s1;
			char_dropped <= dropped_s1;
			fill_count   <= fill_s1;
		end
	end

endmodule

[verif/tb_ps2_set2_keyboard_decoder_fifo_top.sv]
`timescale 1ns / 1ps

module tb_ps2_set2_keyboard_decoder_fifo_top;
	import ps2kd_pkg::*;

	localparam int RING_DEPTH = 128;
	localparam int CYCLE_LIMIT = 200000;
	localparam int RANDOM_BEATS = 850;
	localparam logic ACT_SCAN = 1'b0;
	localparam logic ACT_READ = 1'b1;
	localparam logic [7:0] CODE_ZERO = 8'h00;
	localparam logic [7:0] CODE_KEY_A = 8'h1C;
	localparam logic [7:0] CODE_ENTER = 8'h5A;
	localparam logic [7:0] CODE_BKSP = 8'h66;
	localparam logic [7:0] CODE_LAST_MAPPED = 8'h6F;
	localparam logic [7:0] CODE_FIRST_UNMAPPED = 8'h70;
	localparam logic [7:0] CODE_TOP = 8'hFF;

	// '~' marks an unmapped slot
	localparam logic [8*112-1:0] PLAIN_KEYS = {
		"~~~~~~~~~~~~~~~~",
		"~~~~~q1~~~zsaw2~",
		"~cxde43~~ vftr5~",
		"~nbhgy6~~~mju78~",
		"~,kio09~~./l;p-~",
		"~~'~[=~~~~\015]~\\~~",
		"~~~~~~\010~~~~~~~~~"
	};
	localparam logic [8*112-1:0] SHIFT_KEYS = {
		"~~~~~~~~~~~~~~~~",
		"~~~~~Q!~~~ZSAW@~",
		"~CXDE$#~~ VFTR%~",
		"~NBHGY^~~~MJU&*~",
		"~<KIO)(~~>?L:P_~",
		"~~\"~{+~~~~\015}~|~~",
		"~~~~~~\010~~~~~~~~~"
	};

	typedef struct packed {
		logic [7:0] rchar;
		logic       rvalid;
		logic       stored;
		logic       dropped;
		logic [7:0] fill;
	} key_result_t;

	typedef struct {
		logic        act;
		logic [7:0]  code;
		bit          typed;
		key_result_t res;
	} stim_row_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic       action = 1'b0;
	logic [7:0] scan_code = 8'h00;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic [7:0] read_char;
	logic       read_valid;
	logic       char_stored;
	logic       char_dropped;
	logic [7:0] fill_count;

	bit          rel_armed, shift_held, ctrl_held;
	logic [7:0]  ring_chars[$];
	key_result_t pending_results[$];
	stim_row_t   stim_rows[$];
	int          fail_count, results_seen, beats_sent, burst_left, cycles;
	int          n_stored, n_drops, n_reads, n_empty;
	bit          offering;

	ps2_set2_keyboard_decoder_fifo_top #(
		.BUFFER_DEPTH(RING_DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.action(action),
		.scan_code(scan_code),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.read_char(read_char),
		.read_valid(read_valid),
		.char_stored(char_stored),
		.char_dropped(char_dropped),
		.fill_count(fill_count)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic key_result_t decode_step(input logic act, input logic [7:0] code);
		key_result_t r;
		logic [7:0] ch;
		int slot;
		r = '0;
		if (act == ACT_READ) begin
			if (ring_chars.size() != 0) begin
				r.rchar = ring_chars.pop_front();
				r.rvalid = 1'b1;
				n_reads++;
			end else begin
				n_empty++;
			end
		end else if (code == CODE_RELEASE) begin
			rel_armed = 1'b1;
		end else begin
			if (code == CODE_LSHIFT) shift_held = !rel_armed;
			if (code == CODE_LCTRL) ctrl_held = !rel_armed;
			if (rel_armed && code != CODE_ZERO) begin
				rel_armed = 1'b0;
			end else begin
				ch = 8'h00;
				if (code <= CODE_LAST_MAPPED) begin
					slot = int'(MAP_SIZE) - 1 - int'(code);
					ch = shift_held ? SHIFT_KEYS[8*slot +: 8] : PLAIN_KEYS[8*slot +: 8];
					if (ch == "~") ch = 8'h00;
				end
				if (ctrl_held && code == CODE_EOT_KEY) ch = CHAR_EOT;
				if (ring_chars.size() >= RING_DEPTH) begin
					r.dropped = 1'b1;
					n_drops++;
				end else begin
					ring_chars.push_back(ch);
					r.stored = 1'b1;
					n_stored++;
				end
			end
		end
		r.fill = 8'(ring_chars.size());
		return r;
	endfunction

	function automatic void note_fail(input string what);
		fail_count++;
		if (fail_count <= 10) $display("%s", what);
	endfunction

	function automatic void add_row(input logic act, input logic [7:0] code, input bit typed,
			input logic [7:0] rchar, input logic rvalid, input logic stored,
			input logic dropped, input logic [7:0] fill);
		stim_row_t row;
		row.act = act;
		row.code = code;
		row.typed = typed;
		row.res = '{rchar, rvalid, stored, dropped, fill};
		stim_rows.push_back(row);
	endfunction

	task automatic offer(input logic act, input logic [7:0] code, input bit typed,
			input key_result_t typed_res);
		key_result_t r;
		int gap;
		in_valid <= 1'b1;
		action <= act;
		scan_code <= code;
		offering = 1'b1;
		do @(posedge clk); while (in_stall !== 1'b0);
		r = decode_step(act, code);
		pending_results.push_back(typed ? typed_res : r);
		beats_sent++;
		if (burst_left > 0) burst_left--;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(1, 6));
			burst_left = int'($urandom_range(1, 24));
			if (gap > 0) begin
				in_valid <= 1'b0;
				offering = 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	task automatic settle_all();
		if (offering) begin
			in_valid <= 1'b0;
			offering = 1'b0;
		end
		do @(posedge clk); while (pending_results.size() != 0);
	endtask

	task automatic run_segment(input int read_pct, input int len);
		int start, kind;
		start = beats_sent;
		while (beats_sent - start < len) begin
			if (int'($urandom_range(0, 99)) < read_pct) begin
				offer(ACT_READ, 8'($urandom_range(0, 255)), 1'b0, '0);
			end else begin
				kind = int'($urandom_range(0, 15));
				if (kind <= 6) begin
					offer(ACT_SCAN, 8'($urandom_range(0, 111)), 1'b0, '0);
				end else if (kind <= 8) begin
					offer(ACT_SCAN, CODE_RELEASE, 1'b0, '0);
					offer(ACT_SCAN, 8'($urandom_range(0, 127)), 1'b0, '0);
				end else if (kind == 9 || kind == 10) begin
					if ($urandom_range(0, 1) == 1) offer(ACT_SCAN, CODE_RELEASE, 1'b0, '0);
					offer(ACT_SCAN, (kind == 9) ? CODE_LSHIFT : CODE_LCTRL, 1'b0, '0);
				end else if (kind == 11) begin
					offer(ACT_SCAN, CODE_LCTRL, 1'b0, '0);
					offer(ACT_SCAN, CODE_EOT_KEY, 1'b0, '0);
					offer(ACT_SCAN, CODE_RELEASE, 1'b0, '0);
					offer(ACT_SCAN, CODE_LCTRL, 1'b0, '0);
				end else if (kind == 12) begin
					offer(ACT_SCAN, CODE_ZERO, 1'b0, '0);
				end else if (kind == 13) begin
					offer(ACT_SCAN, 8'($urandom_range(112, 255)), 1'b0, '0);
				end else begin
					offer(ACT_SCAN, 8'($urandom_range(0, 255)), 1'b0, '0);
				end
			end
		end
	endtask

	always @(posedge clk) begin
		key_result_t want, got;
		if (arst_n && out_valid === 1'b1 && out_stall == 1'b0) begin
			got.rchar = read_char;
			got.rvalid = read_valid;
			got.stored = char_stored;
			got.dropped = char_dropped;
			got.fill = fill_count;
			results_seen++;
			if (pending_results.size() == 0) begin
				note_fail($sformatf("result beat %0d with nothing expected", results_seen));
			end else begin
				want = pending_results.pop_front();
				if (got.rchar !== want.rchar || got.rvalid !== want.rvalid
						|| got.stored !== want.stored || got.dropped !== want.dropped
						|| got.fill !== want.fill)
					note_fail($sformatf({"beat %0d: expected char %h valid %b stored %b ",
						"dropped %b fill %0d, got char %h valid %b stored %b dropped %b ",
						"fill %0d"}, results_seen, want.rchar, want.rvalid, want.stored,
						want.dropped, want.fill, got.rchar, got.rvalid, got.stored,
						got.dropped, got.fill));
			end
		end
	end

	initial begin
		int span_left, hold_left, pct;
		bit hold_done;
		span_left = 0;
		hold_left = 0;
		pct = 0;
		hold_done = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (!hold_done && results_seen >= 60) begin
				hold_done = 1'b1;
				hold_left = 150;
			end
			if (span_left == 0) begin
				span_left = int'($urandom_range(10, 80));
				case ($urandom_range(0, 3))
					0, 1: pct = 0;
					2: pct = 25;
					default: pct = 60;
				endcase
			end
			span_left--;
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= (int'($urandom_range(0, 99)) < pct);
			end
		end
	end

	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > CYCLE_LIMIT) begin
				$display("timeout after %0d cycles, %0d results outstanding", cycles,
					pending_results.size());
				$display("tb_ps2_set2_keyboard_decoder_fifo_top: errors");
				$finish;
			end
		end
	end

	initial begin
		int rand_start, pick, pct;
		bit paused;
		paused = 1'b0;
		burst_left = 1;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		add_row(ACT_READ, CODE_ZERO, 1, 8'h00, 0, 0, 0, 8'd0);
		add_row(ACT_SCAN, CODE_ZERO, 1, 8'h00, 0, 1, 0, 8'd1);
		add_row(ACT_SCAN, CODE_TOP, 1, 8'h00, 0, 1, 0, 8'd2);
		add_row(ACT_SCAN, CODE_KEY_A, 0, 8'h00, 0, 0, 0, 8'd0);
		add_row(ACT_SCAN, CODE_LSHIFT, 1, 8'h00, 0, 1, 0, 8'd4);
		add_row(ACT_SCAN, CODE_KEY_A, 0, 8'h00, 0, 0, 0, 8'd0);
		add_row(ACT_SCAN, CODE_RELEASE, 1, 8'h00, 0, 0, 0, 8'd5);
		add_row(ACT_SCAN, CODE_ZERO, 1, 8'h00, 0, 1, 0, 8'd6);
		add_row(ACT_SCAN, CODE_LSHIFT, 1, 8'h00, 0, 0, 0, 8'd6);
		add_row(ACT_SCAN, CODE_LCTRL, 1, 8'h00, 0, 1, 0, 8'd7);
		add_row(ACT_SCAN, CODE_EOT_KEY, 1, 8'h00, 0, 1, 0, 8'd8);
		add_row(ACT_SCAN, CODE_LSHIFT, 0, 8'h00, 0, 0, 0, 8'd0);
		add_row(ACT_SCAN, CODE_EOT_KEY, 0, 8'h00, 0, 0, 0, 8'd0);
		add_row(ACT_SCAN, CODE_RELEASE, 0, 8'h00, 0, 0, 0, 8'd0);
		add_row(ACT_SCAN, CODE_LCTRL, 0, 8'h00, 0, 0, 0, 8'd0);
		add_row(ACT_SCAN, CODE_RELEASE, 0, 8'h00, 0, 0, 0, 8'd0);
		add_row(ACT_SCAN, CODE_LSHIFT, 0, 8'h00, 0, 0, 0, 8'd0);
		add_row(ACT_SCAN, CODE_LAST_MAPPED, 0, 8'h00, 0, 0, 0, 8'd0);
		add_row(ACT_SCAN, CODE_FIRST_UNMAPPED, 0, 8'h00, 0, 0, 0, 8'd0);
		add_row(ACT_SCAN, CODE_ENTER, 0, 8'h00, 0, 0, 0, 8'd0);
		add_row(ACT_SCAN, CODE_BKSP, 0, 8'h00, 0, 0, 0, 8'd0);
		add_row(ACT_SCAN, CODE_RELEASE, 0, 8'h00, 0, 0, 0, 8'd0);
		add_row(ACT_SCAN, CODE_RELEASE, 0, 8'h00, 0, 0, 0, 8'd0);
		add_row(ACT_SCAN, CODE_KEY_A, 0, 8'h00, 0, 0, 0, 8'd0);
		add_row(ACT_READ, CODE_TOP, 1, 8'h00, 1, 0, 0, 8'd13);
		add_row(ACT_READ, CODE_ZERO, 0, 8'h00, 0, 0, 0, 8'd0);
		add_row(ACT_READ, CODE_ZERO, 0, 8'h00, 0, 0, 0, 8'd0);
		foreach (stim_rows[i])
			offer(stim_rows[i].act, stim_rows[i].code, stim_rows[i].typed, stim_rows[i].res);
		settle_all();

		// fill past capacity, then drain past empty
		rand_start = beats_sent;
		run_segment(5, 300);
		run_segment(90, 160);
		while (beats_sent - rand_start < RANDOM_BEATS) begin
			if (!paused && beats_sent - rand_start >= RANDOM_BEATS / 2) begin
				paused = 1'b1;
				settle_all();
			end
			pick = int'($urandom_range(0, 2));
			pct = (pick == 0) ? 5 : (pick == 1) ? 45 : 90;
			run_segment(pct, int'($urandom_range(40, 160)));
		end
		settle_all();
		repeat (20) @(posedge clk);

		$display("%0d beats in %0d cycles: %0d chars queued, %0d dropped on a full ring",
			beats_sent, cycles, n_stored, n_drops);
		$display("%0d reads returned a char, %0d found the ring empty; %0d mismatches",
			n_reads, n_empty, fail_count);
		if (fail_count == 0) begin
			$display("tb_ps2_set2_keyboard_decoder_fifo_top: clean");
		end else begin
			$display("tb_ps2_set2_keyboard_decoder_fifo_top: errors");
		end
		$finish;
	end

endmodule

[sim.f]
rtl/core/ps2kd_pkg.sv
rtl/core/ps2kd_ram.sv
rtl/core/ps2_set2_keyboard_decoder_fifo_top.sv
verif/tb_ps2_set2_keyboard_decoder_fifo_top.sv
